// ----- hdl/gsc_pkg.sv -----
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and constants for the geodetic to Cartesian converter
// Field widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int ANGLE_W = 32;
	localparam int ALT_W   = 31;
	localparam int RAD_W   = 33;
	localparam int OUT_W   = 35;
	localparam int RHO_W   = 35;
	localparam int TRIG_W  = 44;
	localparam int Z_W     = 64;

	localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
	localparam logic [29:0] PI_HI        = 30'h3243F6A8;
	localparam logic [31:0] PI_LO        = 32'h885A308D;
	localparam logic [63:0] GAIN_Q40     = 64'd667681663043;
	localparam logic [RAD_W-1:0] RADIUS_RESET = 33'd6371000000;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [Z_W-1:0]    zang_t;

	// restoring division, evaluated on constants only
	function automatic logic [63:0] udiv_const(input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// arctangent of 2^-i in Q60 radians, built from the series
	function automatic zang_t atan_q60(input int i);
		logic [63:0] sum;
		logic [63:0] t;
		int          e;
		sum = '0;
		if (i == 0) begin
			sum = PI_Q60 >> 2;
		end else begin
			for (int k = 0; k < 64; k++) begin
				e = i * (2 * k + 1);
				if (e <= 60) begin
					t   = udiv_const(64'd1 << (60 - e), 64'(2 * k + 1));
					sum = k[0] ? sum - t : sum + t;
				end
			end
		end
		return zang_t'(sum);
	endfunction

endpackage

// ----- hdl/gsc_sincos.sv -----
// ----------------------------------------------------------------------------
// gsc_sincos: pipelined sine and cosine of a binary angle
// Quadrant fold, conversion to Q60 radians, one CORDIC rotation per stage.
// ----------------------------------------------------------------------------
module gsc_sincos
	import gsc_pkg::*;
#(
	parameter int STEPS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      out_valid,
	output trig_t                     cos_q40,
	output trig_t                     sin_q40
);

	localparam logic [63:0] X0_ADD = (2 * STEPS <= 62) ?
		(((2 * GAIN_Q40) / 3) >> (2 * STEPS)) : 64'd0;
	localparam trig_t X0 = trig_t'(GAIN_Q40 + X0_ADD);

	logic signed [32:0] a_ext;
	logic signed [32:0] a_red;
	logic signed [32:0] a_abs;
	logic               flip_c;

	always_comb begin
		a_ext  = {angle[ANGLE_W-1], angle};
		a_red  = a_ext;
		flip_c = 1'b0;
		if (a_ext > 33'sd1073741824) begin
			a_red  = a_ext - 33'sd2147483648;
			flip_c = 1'b1;
		end else if (a_ext < -33'sd1073741824) begin
			a_red  = a_ext + 33'sd2147483648;
			flip_c = 1'b1;
		end
		a_abs = a_red[32] ? -a_red : a_red;
	end

	logic        v_s1, neg_s1, flip_s1;
	logic [30:0] m_s1;
	logic        v_s2, neg_s2, flip_s2;
	logic [60:0] ph_s2;
	logic [62:0] pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= a_red[32];
			flip_s1 <= flip_c;
			m_s1    <= a_abs[30:0];
			neg_s2  <= neg_s1;
			flip_s2 <= flip_s1;
			ph_s2   <= m_s1 * PI_HI;
			pl_s2   <= m_s1 * PI_LO;
		end
	end

	logic [62:0] zu_c;
	assign zu_c = {1'b0, ph_s2, 1'b0} + 63'(pl_s2 >> 31);

	// index 0 is the start vector, index i+1 follows rotation i
	logic  v_s    [0:STEPS];
	logic  flip_s [0:STEPS];
	trig_t x_s    [0:STEPS];
	trig_t y_s    [0:STEPS];
	zang_t z_s    [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flip_s[0] <= flip_s2;
			x_s[0]    <= X0;
			y_s[0]    <= '0;
			z_s[0]    <= neg_s2 ? -zang_t'({1'b0, zu_c}) : zang_t'({1'b0, zu_c});
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		localparam zang_t AT = atan_q60(i);
		trig_t dx, dy;
		assign dx = x_s[i] >>> i;
		assign dy = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][Z_W-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + dx;
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - dx;
					z_s[i+1] <= z_s[i] + AT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[STEPS];
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		if (en) begin
			cos_q40 <= flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
			sin_q40 <= flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		end
	end

endmodule

// ----- hdl/gsc_mul.sv -----
// ----------------------------------------------------------------------------
// gsc_mul: pipelined Q40 product with rounding half away from zero
// Sign and magnitude split, four registered partial products, final sum.
// ----------------------------------------------------------------------------
module gsc_mul
	import gsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  trig_t a,
	input  trig_t b,
	output logic  out_valid,
	output trig_t p
);

	localparam int H = TRIG_W / 2;
	localparam int P_W = 2 * TRIG_W;

	logic              v_s1, neg_s1;
	logic [TRIG_W-1:0] ua_s1, ub_s1;
	logic              v_s2, neg_s2;
	logic [2*H-1:0]    pll_s2, plh_s2, phl_s2, phh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	logic [P_W-1:0] sum_c;
	logic [P_W-1:0] rnd_c;
	assign sum_c = (P_W'(phh_s2) << (2 * H)) + (P_W'(plh_s2) << H)
		+ (P_W'(phl_s2) << H) + P_W'(pll_s2) + (P_W'(1) << 39);
	assign rnd_c = sum_c >> 40;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[TRIG_W-1] ^ b[TRIG_W-1];
			ua_s1  <= a[TRIG_W-1] ? TRIG_W'(-a) : TRIG_W'(a);
			ub_s1  <= b[TRIG_W-1] ? TRIG_W'(-b) : TRIG_W'(b);
			neg_s2 <= neg_s1;
			pll_s2 <= ua_s1[H-1:0] * ub_s1[H-1:0];
			plh_s2 <= ua_s1[H-1:0] * ub_s1[2*H-1:H];
			phl_s2 <= ua_s1[2*H-1:H] * ub_s1[H-1:0];
			phh_s2 <= ua_s1[2*H-1:H] * ub_s1[2*H-1:H];
			p      <= neg_s2 ? -trig_t'(rnd_c[TRIG_W-1:0]) : trig_t'(rnd_c[TRIG_W-1:0]);
		end
	end

endmodule

// ----- hdl/gsc_skid.sv -----
// ----------------------------------------------------------------------------
// gsc_skid: two-entry output buffer
// Registered result plus one skid entry; ready to the pipeline is registered.
// ----------------------------------------------------------------------------
module gsc_skid
	import gsc_pkg::*;
#(
	parameter int W = 112
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         in_ready,
	output logic         out_valid,
	output logic [W-1:0] out_data,
	input  logic         out_ready
);

	logic         skid_valid_q;
	logic [W-1:0] skid_data_q;
	logic         in_fire;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_valid_q) begin
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			out_data <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule

// ----- hdl/spherical_geodetic_to_cartesian_unit.sv -----
// ----------------------------------------------------------------------------
// spherical_geodetic_to_cartesian_unit: geodetic to Earth-centred Cartesian
// Spherical Earth, CORDIC sine and cosine, rounded millimetre results.
// ----------------------------------------------------------------------------
// channel    | direction | handshake          | payload
// s_axis     | in        | s_tvalid/s_tready  | latitude, longitude, altitude
// m_axis     | out       | m_tvalid/m_tready  | x, y, z
// cfg        | in        | cfg_valid/cfg_ready| sphere radius in mm
//
// One position enters per cycle while the output is not stalled; latency is set
// by the CORDIC stage chain, two multiplier rows and the output buffer.
// Reset clears all valid bits and loads the default radius.
// A stalled output fills a skid entry, then the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module spherical_geodetic_to_cartesian_unit
	import gsc_pkg::*;
#(
	parameter int CORDIC_STEPS = 28
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// [31:0] latitude_angle, [63:32] longitude_angle, [94:64] altitude_mm
	input  logic [95:0]       s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [34:0] x_mm, [69:35] y_mm, [104:70] z_mm
	output logic [111:0]      m_tdata,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [RAD_W-1:0]  cfg_data
);

	localparam int SC_LAT  = CORDIC_STEPS + 4;
	localparam int MUL_LAT = 3;

	logic             en;
	logic [RAD_W-1:0] radius_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= cfg_data;
		end
	end

	logic signed [RHO_W-1:0] rho_c;
	assign rho_c = $signed({2'b00, radius_q})
		+ RHO_W'($signed(s_tdata[64 +: ALT_W]));

	logic  lat_v, lon_v;
	trig_t cl, sl, co, so;

	gsc_sincos #(.STEPS(CORDIC_STEPS)) u_lat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.angle    ($signed(s_tdata[31:0])),
		.out_valid(lat_v),
		.cos_q40  (cl),
		.sin_q40  (sl)
	);

	gsc_sincos #(.STEPS(CORDIC_STEPS)) u_lon (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.angle    ($signed(s_tdata[63:32])),
		.out_valid(lon_v),
		.cos_q40  (co),
		.sin_q40  (so)
	);

	// radius sum rides alongside the trig and first multiplier rows
	logic signed [RHO_W-1:0] rho_s [0:SC_LAT+MUL_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			rho_s[0] <= rho_c;
			for (int k = 1; k < SC_LAT + MUL_LAT; k++) begin
				rho_s[k] <= rho_s[k-1];
			end
		end
	end

	trig_t rho_a, rho_b;
	assign rho_a = TRIG_W'(rho_s[SC_LAT-1]);
	assign rho_b = TRIG_W'(rho_s[SC_LAT+MUL_LAT-1]);

	logic  v1a, v1b, v1c;
	trig_t cc, cs, pz;

	gsc_mul u_mcc (.clk(clk), .arst_n(arst_n), .en(en), .in_valid(lat_v),
		.a(cl), .b(co), .out_valid(v1a), .p(cc));
	gsc_mul u_mcs (.clk(clk), .arst_n(arst_n), .en(en), .in_valid(lon_v),
		.a(cl), .b(so), .out_valid(v1b), .p(cs));
	gsc_mul u_mz (.clk(clk), .arst_n(arst_n), .en(en), .in_valid(lat_v),
		.a(rho_a), .b(sl), .out_valid(v1c), .p(pz));

	// hold z until x and y leave the second row
	trig_t pz_s [0:MUL_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			pz_s[0] <= pz;
			for (int k = 1; k < MUL_LAT; k++) begin
				pz_s[k] <= pz_s[k-1];
			end
		end
	end

	logic  v2x, v2y;
	trig_t px, py;

	gsc_mul u_mx (.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1a && v1c),
		.a(rho_b), .b(cc), .out_valid(v2x), .p(px));
	gsc_mul u_my (.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v1b),
		.a(rho_b), .b(cs), .out_valid(v2y), .p(py));

	logic [111:0] res_c;
	assign res_c = {7'd0, pz_s[MUL_LAT-1][OUT_W-1:0], py[OUT_W-1:0], px[OUT_W-1:0]};

	gsc_skid #(.W(112)) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v2x && v2y),
		.in_data  (res_c),
		.in_ready (en),
		.out_valid(m_tvalid),
		.out_data (m_tdata),
		.out_ready(m_tready)
	);

endmodule

// ----- verif/spherical_geodetic_to_cartesian_unit_test.sv -----
// ----------------------------------------------------------------------------
// spherical_geodetic_to_cartesian_unit_test: self-checking bench for the
// geodetic to Cartesian converter. Positions stream in with random gaps, the
// result stream stalls at random, and every result is compared with a
// bit-exact CORDIC predictor across several sphere radius settings.
// ----------------------------------------------------------------------------
module spherical_geodetic_to_cartesian_unit_test;
	import gsc_pkg::*;

	localparam int STEPS     = 28;
	localparam int LATENCY   = STEPS + 12;
	localparam int MAX_CYCLES = 400000;
	localparam logic signed [63:0] QUARTER = 64'sd1073741824;
	localparam logic signed [63:0] HALF    = 64'sd2147483648;

	typedef struct packed {
		logic [OUT_W-1:0] z;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] x;
	} position_xyz_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [95:0]       s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [111:0]      m_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [RAD_W-1:0]  cfg_data;

	int error_count;
	int cycle_count;
	bit stall_enable;

	spherical_geodetic_to_cartesian_unit #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
		input logic [OUT_W-1:0] want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what,
			$signed(got), $signed(want), cycle_count);
		error_count++;
	endtask

	// floor shift of a signed value
	function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	// series arctangent of 2^-i in Q60
	function automatic logic signed [63:0] arctan_q60(input int i);
		logic signed [63:0] acc;
		logic [63:0]        term;
		int                 e;
		acc = 0;
		if (i == 0) return 64'sh3243F6A8885A308D >>> 2;
		for (int k = 0; k < 64; k++) begin
			e = i * (2 * k + 1);
			if (e > 60) break;
			term = (64'd1 << (60 - e)) / (2 * k + 1);
			acc = k[0] ? acc - $signed(term) : acc + $signed(term);
		end
		return acc;
	endfunction

	// rounded Q40 product, half away from zero
	function automatic logic signed [63:0] mul_q40(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [127:0] p;
		logic [63:0]  ua, ub;
		logic signed [63:0] r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = ua * ub + (128'd1 << 39);
		r = $signed(p[103:40]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic void binary_angle_sincos(input logic [31:0] ang,
		output logic signed [63:0] c, output logic signed [63:0] s);
		logic signed [63:0] a, x, y, z, dx, dy;
		logic [63:0]        m;
		bit                 flip;
		a = $signed({{32{ang[31]}}, ang});
		flip = 0;
		if (a > QUARTER) begin
			a = a - HALF;
			flip = 1;
		end else if (a < -QUARTER) begin
			a = a + HALF;
			flip = 1;
		end
		m = a < 0 ? -a : a;
		z = $signed(2 * m * 64'h3243F6A8 + ((m * 64'h885A308D) >> 31));
		if (a < 0) z = -z;
		x = $signed(GAIN_Q40);
		if (2 * STEPS <= 62) x = x + $signed(((2 * GAIN_Q40) / 3) >> (2 * STEPS));
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_q60(i);
			end else begin
				x += dx; y -= dy; z += arctan_q60(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	class position_scoreboard;
		position_xyz_t      pending[$];
		logic [RAD_W-1:0]   radius;

		function void note_position(input logic [95:0] d);
			logic signed [63:0] cl, sl, co, so, rho;
			position_xyz_t      e;
			binary_angle_sincos(d[31:0], cl, sl);
			binary_angle_sincos(d[63:32], co, so);
			rho = $signed({31'd0, radius}) + $signed({{33{d[94]}}, d[94:64]});
			e.x = OUT_W'(mul_q40(rho, mul_q40(cl, co)));
			e.y = OUT_W'(mul_q40(rho, mul_q40(cl, so)));
			e.z = OUT_W'(mul_q40(rho, sl));
			pending.insert(pending.size(), e);
		endfunction

		task check_result(input logic [111:0] d);
			position_xyz_t e;
			if (pending.size() == 0) begin
				$display("unexpected result at cycle %0d", cycle_count);
				error_count++;
				return;
			end
			e = pending.pop_front();
			if (d[34:0] !== e.x) report_mismatch("x_mm", d[34:0], e.x);
			if (d[69:35] !== e.y) report_mismatch("y_mm", d[69:35], e.y);
			if (d[104:70] !== e.z) report_mismatch("z_mm", d[104:70], e.z);
			if (d[111:105] !== 0) report_mismatch("pad", d[111:105], 0);
		endtask
	endclass

	position_scoreboard positions;

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// sample at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && m_tvalid && m_tready) positions.check_result(m_tdata);
		if (arst_n && s_tvalid && s_tready) positions.note_position(s_tdata);
		if (cycle_count > MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side stalls in bursts
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_enable && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 9);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_radius(input logic [RAD_W-1:0] r);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		positions.radius = r;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results;
		while (positions.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic send_position(input logic [31:0] lat, input logic [31:0] lon,
		input logic [30:0] alt);
		@(negedge clk);
		if (stall_enable && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, alt, lon, lat};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_input;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] random_latitude();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
			2: return $urandom_range(0, 1) ? 32'h40000000 : 32'hC0000000;
			default: return 32'($urandom_range(0, 32'h3FFFFFFF) ^ {32{$urandom_range(0, 1) == 1}});
		endcase
	endfunction

	function automatic logic [30:0] random_altitude();
		case ($urandom_range(0, 3))
			0: return 31'($urandom());
			1: return 31'($urandom_range(0, 1010000000) - 10000000);
			default: return 31'($urandom_range(0, 20000));
		endcase
	endfunction

	initial begin
		logic [31:0] angles[8];
		logic [RAD_W-1:0] radii[5];
		angles = '{32'h00000000, 32'h40000000, 32'hC0000000, 32'h7FFFFFFF,
			32'h80000000, 32'h40000001, 32'hBFFFFFFF, 32'h20000000};
		radii = '{33'd6371000000, 33'd0, 33'h1FFFFFFFF, 33'd8000000000, 33'd1};
		positions = new();
		positions.radius = RADIUS_RESET;
		error_count = 0;
		cycle_count = 0;
		stall_enable = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: angle extremes and quadrant wraps, altitude extremes
		for (int i = 0; i < 8; i++)
			send_position(angles[i], angles[7 - i], 31'($urandom()));
		send_position(32'h12345678, 32'hFFFFFFFF, 31'h3FFFFFFF);
		send_position(32'hEDCBA988, 32'h00000001, 31'h40000000);
		send_position(32'h40000000, 32'h80000000, 31'h7FFFFFFF);
		send_position(32'h00000000, 32'h00000000, 31'($signed(-32'sd10000000)));
		send_position(32'h20000000, 32'h60000000, 31'd1000000000);
		idle_input();

		for (int phase = 0; phase < 5; phase++) begin
			drain_results();
			write_radius(radii[phase]);
			for (int n = 0; n < 250; n++) begin
				if (phase == 4 && n == 150) stall_enable = 1'b0;
				if (n == 100 && phase == 2) begin
					idle_input();
					while (positions.pending.size() != 0) @(negedge clk);
				end
				send_position(random_latitude(), $urandom(), random_altitude());
			end
			idle_input();
		end

		while (positions.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
